// ===== hdl/pngsu_pkg.sv =====
// shared constants for the png scanline unfilter
// field widths, parameter defaults, filter type and register index codes
// no dependencies
package pngsu_pkg;

    localparam int DATA_W              = 8;
    localparam int BPP_W               = 4;
    localparam int ROW_W               = 13;
    localparam int MAX_ROW_BYTES_DEF   = 4096;
    localparam int MAX_PIXEL_BYTES_DEF = 8;

    // filter type codes as held for the row
    localparam logic [2:0] FLT_NONE  = 3'd0;
    localparam logic [2:0] FLT_SUB   = 3'd1;
    localparam logic [2:0] FLT_UP    = 3'd2;
    localparam logic [2:0] FLT_AVG   = 3'd3;
    localparam logic [2:0] FLT_PAETH = 3'd4;
    localparam logic [2:0] FLT_BAD   = 3'd7;

    // highest filter type byte that has a meaning
    localparam logic [DATA_W-1:0] FLT_MAX_CODE = 8'd4;

    // configuration register indexes
    localparam logic CFG_BPP = 1'b0;
    localparam logic CFG_ROW = 1'b1;

endpackage

// ===== hdl/pngsu_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
module pngsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/png_scanline_unfilter.sv =====
// png scanline filter reconstruction, top level
// depends on pngsu_pkg and pngsu_ram
//
// usage
//   input channel (i_valid / o_stall) takes the inflated image stream, one
//   byte per beat. the first beat of every row is the filter type byte and
//   yields no output beat. i_start_of_image marks the row 0 filter byte and
//   abandons any row in progress.
//   output channel (o_valid / i_stall) gives one reconstructed byte per
//   pixel beat, with o_row_end on the last byte of a row and o_bad_filter
//   on every byte of a row whose filter type was above 4 (byte unchanged).
//   config channel (i_cfg_valid / o_cfg_ready) writes bytes_per_pixel
//   (index 0) and row_bytes (index 1); write only while the block is idle.
// timing
//   a beat is registered in the compute stage, then the output register. one
//   byte per cycle sustained while not stalled: the front stage reads the line
//   store, the second stage forms the predictor from the read data and writes
//   the byte back in the same row slot; the line store port pair sets that rate.
// reset and stall
//   synchronous reset clears control state and both histories and sets
//   bytes_per_pixel = 1, row_bytes = 1; the line store is not cleared.
//   under output stall one result waits in the output register and one more
//   in the compute stage before o_stall is raised.
module png_scanline_unfilter
    import pngsu_pkg::*;
#(
    parameter int MAX_ROW_BYTES   = MAX_ROW_BYTES_DEF,
    parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input stream
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [DATA_W-1:0] i_data_byte,
    input  logic              i_start_of_image,
    // output stream
    output logic              o_valid,
    input  logic              i_stall,
    output logic [DATA_W-1:0] o_pixel_byte,
    output logic              o_row_end,
    output logic              o_bad_filter,
    // configuration writes
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [ROW_W-1:0]  i_cfg_data
);

    // column counter holds 0 .. MAX_ROW_BYTES, line store address 0 .. MAX-1
    localparam int CW = $clog2(MAX_ROW_BYTES + 1);
    localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int LW = (CW > ROW_W) ? CW : ROW_W;
    localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int BW = (PW + 1 > BPP_W) ? PW + 1 : BPP_W;

    function automatic logic [DATA_W-1:0] paeth(
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b,
        input logic [DATA_W-1:0] c
    );
        logic signed [10:0] p;
        logic signed [10:0] da;
        logic signed [10:0] db;
        logic signed [10:0] dc;
        logic [10:0]        pa;
        logic [10:0]        pb;
        logic [10:0]        pc;
        p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
        da = p - $signed({3'b000, a});
        db = p - $signed({3'b000, b});
        dc = p - $signed({3'b000, c});
        pa = (da < 0) ? 11'(-da) : 11'(da);
        pb = (db < 0) ? 11'(-db) : 11'(db);
        pc = (dc < 0) ? 11'(-dc) : 11'(dc);
        // ties go to a, then b, then c
        if (pa <= pb && pa <= pc) begin
            paeth = a;
        end else if (pb <= pc) begin
            paeth = b;
        end else begin
            paeth = c;
        end
    endfunction

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [BPP_W-1:0] r_bpp;
    logic [ROW_W-1:0] r_row_bytes;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp       <= BPP_W'(1);
            r_row_bytes <= ROW_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BPP: r_bpp       <= i_cfg_data[BPP_W-1:0];
                CFG_ROW: r_row_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective row length, 0 acts as 1 and anything above the store as max
    logic [LW-1:0] row_len;
    always_comb begin
        if (r_row_bytes == '0) begin
            row_len = LW'(1);
        end else if (LW'(r_row_bytes) > LW'(MAX_ROW_BYTES)) begin
            row_len = LW'(MAX_ROW_BYTES);
        end else begin
            row_len = LW'(r_row_bytes);
        end
    end

    // effective pixel distance as a history tap
    logic [BW-1:0] bpp_ext;
    logic [PW-1:0] tap;
    always_comb begin
        bpp_ext = BW'(r_bpp);
        if (bpp_ext == '0) begin
            bpp_ext = BW'(1);
        end else if (bpp_ext > BW'(MAX_PIXEL_BYTES)) begin
            bpp_ext = BW'(MAX_PIXEL_BYTES);
        end
        tap = PW'(bpp_ext - BW'(1));
    end

    // ---------------------------------------------------------------
    // front stage: row tracking and line store read
    // ---------------------------------------------------------------
    logic [CW-1:0] r_col;
    logic          r_first_row;
    logic          r_expect_flt;
    logic [2:0]    r_kind;
    logic [CW-1:0] n_col;
    logic          n_first_row;
    logic          n_expect_flt;
    logic [2:0]    n_kind;

    // compute stage registers
    logic              r_s2_valid;
    logic              r_s2_filter;
    logic [DATA_W-1:0] r_s2_x;
    logic              r_s2_first;
    logic              r_s2_last;
    logic [2:0]        r_s2_kind;
    logic [AW-1:0]     r_s2_addr;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_pixel;
    logic              r_row_end;
    logic              r_bad;

    logic          in_acc;
    logic          s2_adv;
    logic          eff_expect;
    logic          eff_first;
    logic [CW-1:0] col_c;
    logic [CW-1:0] col_inc;
    logic          col_last;

    // filter beats in the compute stage never wait for the output register
    assign s2_adv  = r_s2_valid && (r_s2_filter || !r_out_valid || !i_stall);
    assign o_stall = r_s2_valid && !s2_adv;
    assign in_acc  = i_valid && !o_stall;

    always_comb begin
        eff_expect = i_start_of_image || r_expect_flt;
        eff_first  = i_start_of_image || r_first_row;
        col_c      = (r_col >= CW'(MAX_ROW_BYTES)) ? CW'(MAX_ROW_BYTES - 1) : r_col;
        col_inc    = col_c + CW'(1);
        col_last   = LW'(col_inc) >= row_len;

        n_col        = r_col;
        n_first_row  = r_first_row;
        n_expect_flt = r_expect_flt;
        n_kind       = r_kind;
        if (in_acc) begin
            if (eff_expect) begin
                n_kind       = (i_data_byte > FLT_MAX_CODE) ? FLT_BAD : i_data_byte[2:0];
                n_col        = '0;
                n_expect_flt = 1'b0;
                n_first_row  = eff_first;
            end else if (col_last) begin
                n_col        = '0;
                n_expect_flt = 1'b1;
                n_first_row  = 1'b0;
            end else begin
                n_col        = col_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_first_row  <= 1'b1;
            r_expect_flt <= 1'b1;
            r_kind       <= FLT_NONE;
        end else begin
            r_col        <= n_col;
            r_first_row  <= n_first_row;
            r_expect_flt <= n_expect_flt;
            r_kind       <= n_kind;
        end
    end

    // hand the beat to the compute stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (in_acc) begin
            r_s2_valid <= 1'b1;
        end else if (s2_adv) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s2_filter <= eff_expect;
            r_s2_x      <= i_data_byte;
            r_s2_first  <= eff_first;
            r_s2_last   <= col_last;
            r_s2_kind   <= r_kind;
            r_s2_addr   <= col_c[AW-1:0];
        end
    end

    // ---------------------------------------------------------------
    // previous row line store
    // a slot is rewritten when its beat leaves the compute stage; the same
    // slot is read again only in the next row, past at least one filter beat
    // ---------------------------------------------------------------
    logic              ram_we;
    logic [DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0] res;

    assign ram_we = s2_adv && !r_s2_filter;

    pngsu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ROW_BYTES)
    ) u_prior_row (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s2_addr),
        .i_wdata (res),
        .i_re    (in_acc && !eff_expect),
        .i_raddr (col_c[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // compute stage: predictor and histories
    // ---------------------------------------------------------------
    logic [DATA_W-1:0] r_left [MAX_PIXEL_BYTES];
    logic [DATA_W-1:0] r_upleft [MAX_PIXEL_BYTES];
    logic [DATA_W-1:0] nb_a;
    logic [DATA_W-1:0] nb_b;
    logic [DATA_W-1:0] nb_c;
    logic [DATA_W:0]   avg_sum;
    logic [DATA_W-1:0] pred;
    logic              bad;

    always_comb begin
        nb_a    = r_left[tap];
        nb_b    = r_s2_first ? '0 : ram_rdata;
        nb_c    = r_upleft[tap];
        avg_sum = {1'b0, nb_a} + {1'b0, nb_b};
        bad     = 1'b0;
        case (r_s2_kind)
            FLT_NONE:  pred = '0;
            FLT_SUB:   pred = nb_a;
            FLT_UP:    pred = nb_b;
            FLT_AVG:   pred = avg_sum[DATA_W:1];
            FLT_PAETH: pred = paeth(nb_a, nb_b, nb_c);
            default: begin
                pred = '0;
                bad  = 1'b1;
            end
        endcase
        res = r_s2_x + pred;
    end

    // histories shift in on each pixel byte, clear on a filter byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                r_left[i]   <= '0;
                r_upleft[i] <= '0;
            end
        end else if (s2_adv) begin
            if (r_s2_filter) begin
                for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                    r_left[i]   <= '0;
                    r_upleft[i] <= '0;
                end
            end else begin
                for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
                    r_left[i]   <= r_left[i-1];
                    r_upleft[i] <= r_upleft[i-1];
                end
                r_left[0]   <= res;
                r_upleft[0] <= nb_b;
            end
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ram_we) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_pixel   <= res;
            r_row_end <= r_s2_last;
            r_bad     <= bad;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pixel_byte = r_pixel;
    assign o_row_end    = r_row_end;
    assign o_bad_filter = r_bad;

endmodule
